>>> sv/dfs_pkg.sv
// Shared types and constants for the depth-first finish-order block.
// Used by dfs_adj_mem and dfs_finish_time_order.
package dfs_pkg;
	localparam int MaxVertices = 64;
	localparam int VW = $clog2(MaxVertices);   // vertex index width
	localparam int CW = VW + 1;                 // count width (0..MaxVertices)

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_RUN   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] src_vertex;
		logic [5:0] dst_vertex;
	} req_t;

	typedef struct packed {
		logic [5:0] vertex_id;
		logic [7:0] finish_stamp;
		logic       last_result;
	} rsp_t;

	typedef logic [MaxVertices-1:0] row_t;
endpackage

>>> sv/dfs_finish_time_order.sv
// Depth-first search over a stored digraph, emitting vertices in decreasing finish order.
// Add edge reads the source row and writes it back with the new bit; clear resets the row valid
// flags; a run searches from each unvisited root in turn, then emits the results.
// The neighbor scan tests one adjacency bit per cycle, pausing while a new row loads.
// Results come one at a time on rsp_strobe; the receiver cannot stall.
// Reset clears the edge matrix (row valid flags), control state and vertex_count to 64.
// Depends on dfs_pkg and dfs_adj_mem.
module dfs_finish_time_order (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dfs_pkg::req_t req,
	output logic          rsp_strobe,
	output dfs_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_data
);
	import dfs_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ADD_WR = 4'd1;
	localparam logic [3:0] ST_ROOT   = 4'd2;
	localparam logic [3:0] ST_LOAD   = 4'd3;
	localparam logic [3:0] ST_SCAN   = 4'd4;
	localparam logic [3:0] ST_POP    = 4'd5;
	localparam logic [3:0] ST_EMIT_A = 4'd6;
	localparam logic [3:0] ST_EMIT_B = 4'd7;
	localparam logic [3:0] ST_EMIT_C = 4'd8;

	logic [3:0]             state_q;
	logic [6:0]             vcount_q;
	logic [CW-1:0]          n_q;
	logic [VW-1:0]          src_q;
	logic [VW-1:0]          dst_q;
	logic [MaxVertices-1:0] visited_q;
	logic [7:0]             stamp_q;
	logic [CW-1:0]          root_q;
	logic [VW-1:0]          cur_v_q;
	logic [CW-1:0]          cur_j_q;
	row_t                   cur_row_q;
	logic [CW-1:0]          sp_q;
	logic [CW-1:0]          nfin_q;
	logic [VW-1:0]          eidx_q;
	logic [VW-1:0]          ev_q;
	logic                   strobe_q;
	rsp_t                   rsp_q;

	// adjacency port
	logic          adj_clr;
	logic          adj_we;
	row_t          adj_wdata;
	logic [VW-1:0] adj_raddr;
	row_t          adj_rdata;

	// stack, finish stamps and finish order
	logic [VW+CW-1:0] stk_mem [MaxVertices];
	logic [7:0]       fin_mem [MaxVertices];
	logic [VW-1:0]    ord_mem [MaxVertices];
	logic [VW+CW-1:0] stk_rdata;
	logic [7:0]       fin_rdata;
	logic [VW-1:0]    ord_rdata;
	logic [VW-1:0]    stk_raddr;

	logic          accept;
	logic [CW-1:0] n_sat;
	logic          at_end;
	logic          take;
	logic [VW-1:0] j_idx;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign n_sat     = (vcount_q > 7'(MaxVertices)) ? CW'(MaxVertices) : CW'(vcount_q);
	assign j_idx     = cur_j_q[VW-1:0];
	assign at_end    = (cur_j_q >= n_q);
	assign take      = !at_end && cur_row_q[j_idx] && !visited_q[j_idx];
	assign stk_raddr = VW'(sp_q - CW'(1));

	assign adj_clr   = accept && (req.req_type == REQ_CLEAR);
	assign adj_we    = (state_q == ST_ADD_WR);
	assign adj_wdata = adj_rdata | (row_t'(1) << dst_q);

	always_comb begin
		case (state_q)
			ST_IDLE:  adj_raddr = req.src_vertex;
			ST_ADD_WR: adj_raddr = src_q;
			ST_ROOT:  adj_raddr = root_q[VW-1:0];
			ST_SCAN:  adj_raddr = j_idx;
			ST_POP:   adj_raddr = stk_rdata[VW+CW-1:CW];
			default:  adj_raddr = cur_v_q;
		endcase
	end

	dfs_adj_mem u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (adj_clr),
		.wr_en   (adj_we),
		.wr_addr (src_q),
		.wr_data (adj_wdata),
		.rd_addr (adj_raddr),
		.rd_data (adj_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && take) begin
			stk_mem[sp_q[VW-1:0]] <= {cur_v_q, cur_j_q + CW'(1)};
		end
		if (state_q == ST_SCAN && at_end) begin
			fin_mem[cur_v_q]          <= stamp_q;
			ord_mem[nfin_q[VW-1:0]]   <= cur_v_q;
		end
		stk_rdata <= stk_mem[stk_raddr];
		ord_rdata <= ord_mem[eidx_q];
		// address by the order entry directly so the stamp is ready in EMIT_C
		fin_rdata <= fin_mem[ord_rdata];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vcount_q  <= 7'(MaxVertices);
			n_q       <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			visited_q <= '0;
			stamp_q   <= 8'd1;
			root_q    <= '0;
			cur_v_q   <= '0;
			cur_j_q   <= '0;
			cur_row_q <= '0;
			sp_q      <= '0;
			nfin_q    <= '0;
			eidx_q    <= '0;
			ev_q      <= '0;
			strobe_q  <= 1'b0;
			rsp_q     <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						src_q <= req.src_vertex;
						dst_q <= req.dst_vertex;
						if (req.req_type == REQ_ADD) begin
							state_q <= ST_ADD_WR;
						end else if (req.req_type == REQ_RUN && n_sat != '0) begin
							n_q       <= n_sat;
							visited_q <= '0;
							stamp_q   <= 8'd1;
							root_q    <= '0;
							nfin_q    <= '0;
							state_q   <= ST_ROOT;
						end
					end
				end
				ST_ADD_WR: state_q <= ST_IDLE;
				ST_ROOT: begin
					if (root_q >= n_q) begin
						eidx_q  <= VW'(nfin_q - CW'(1));
						state_q <= ST_EMIT_A;
					end else if (visited_q[root_q[VW-1:0]]) begin
						root_q <= root_q + CW'(1);
					end else begin
						visited_q[root_q[VW-1:0]] <= 1'b1;
						stamp_q <= stamp_q + 8'd1;
						cur_v_q <= root_q[VW-1:0];
						cur_j_q <= '0;
						sp_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cur_row_q <= adj_rdata;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (at_end) begin
						// finish this vertex, then resume parent or next root
						stamp_q <= stamp_q + 8'd1;
						nfin_q  <= nfin_q + CW'(1);
						if (sp_q == '0) begin
							root_q  <= root_q + CW'(1);
							state_q <= ST_ROOT;
						end else begin
							sp_q    <= sp_q - CW'(1);
							state_q <= ST_POP;
						end
					end else if (take) begin
						visited_q[j_idx] <= 1'b1;
						stamp_q <= stamp_q + 8'd1;
						sp_q    <= sp_q + CW'(1);
						cur_v_q <= j_idx;
						cur_j_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						cur_j_q <= cur_j_q + CW'(1);
					end
				end
				ST_POP: begin
					cur_v_q <= stk_rdata[VW+CW-1:CW];
					cur_j_q <= stk_rdata[CW-1:0];
					state_q <= ST_LOAD;
				end
				ST_EMIT_A: state_q <= ST_EMIT_B;
				ST_EMIT_B: begin
					ev_q    <= ord_rdata;
					state_q <= ST_EMIT_C;
				end
				ST_EMIT_C: begin
					strobe_q <= 1'b1;
					rsp_q.vertex_id    <= ev_q;
					rsp_q.finish_stamp <= fin_rdata;
					rsp_q.last_result  <= (eidx_q == '0);
					if (eidx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						eidx_q  <= eidx_q - VW'(1);
						state_q <= ST_EMIT_A;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_strobe = strobe_q;
	assign rsp        = rsp_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && take) |-> (sp_q < n_q))
		else $error("stack push beyond vertex count");
	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_C) |=> rsp_strobe)
		else $error("emit step without result strobe");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_strobe && rsp.last_result) |-> (state_q == ST_IDLE))
		else $error("last result while run still active");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cur_j_q <= n_q))
		else $error("scan index past vertex count");
endmodule

>>> sv/dfs_adj_mem.sv
// Adjacency bit matrix: one row per source vertex, synchronous read.
// Per-row valid flags give an instant clear; depends on dfs_pkg.
module dfs_adj_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                wr_en,
	input  logic [dfs_pkg::VW-1:0] wr_addr,
	input  dfs_pkg::row_t       wr_data,
	input  logic [dfs_pkg::VW-1:0] rd_addr,
	output dfs_pkg::row_t       rd_data
);
	import dfs_pkg::*;

	row_t                   mem [MaxVertices];
	logic [MaxVertices-1:0] vld_q;
	row_t                   rdat_s1;
	logic                   rvld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdat_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= vld_q[rd_addr];
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// rows never written since the last clear read as empty
	assign rd_data = rvld_s1 ? rdat_s1 : '0;
endmodule
